>>> rtl/core/sfm_pkg.sv
// ----------------------------------------------------------------------------
// sfm_pkg
// Shared widths, register indexes and the queue entry control word of the
// substring first match unit.
// ----------------------------------------------------------------------------
package sfm_pkg;

	localparam int BYTE_W      = 8;
	localparam int PAT_W       = 64;
	localparam int PAT_BYTES   = PAT_W / BYTE_W;
	localparam int PAT_IDX_W   = $clog2(PAT_BYTES);
	localparam int PLEN_W      = 4;
	localparam int START_W     = 16;
	localparam int CFG_IDX_W   = 1;

	localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_BYTES  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH = 1'd1;

	typedef struct packed {
		logic take;
		logic last;
		logic too_long;
	} sfm_ctl_t;

	localparam int CTL_W = $bits(sfm_ctl_t);

endpackage

>>> rtl/core/sfm_front.sv
// ----------------------------------------------------------------------------
// sfm_front
// Accepts text transactions, counts text position with saturation, tracks
// overflow and drops items that carry neither a counted byte nor an end mark.
// ----------------------------------------------------------------------------
module sfm_front #(
	parameter int MAX_TEXT = 65536,
	parameter int POS_W    = 17
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        text_valid,
	output logic                        text_stall,
	input  logic [sfm_pkg::BYTE_W-1:0]  text_byte,
	input  logic                        has_byte,
	input  logic                        last,
	input  logic                        queue_full,
	output logic                        push,
	output sfm_pkg::sfm_ctl_t           push_ctl,
	output logic [sfm_pkg::BYTE_W-1:0]  push_byte,
	output logic [POS_W-1:0]            push_pos
);

	logic [POS_W-1:0] pos_q;
	logic             ovf_q;
	logic             accept;
	logic             at_limit;
	logic             take;
	logic             drop_byte;

	assign text_stall = queue_full;
	assign accept     = text_valid && !text_stall;
	assign at_limit   = (pos_q == POS_W'(MAX_TEXT));
	assign take       = has_byte && !at_limit;
	assign drop_byte  = has_byte && at_limit;

	assign push              = accept && (take || last);
	assign push_ctl.take     = take;
	assign push_ctl.last     = last;
	assign push_ctl.too_long = ovf_q || drop_byte;
	assign push_byte         = text_byte;
	assign push_pos          = pos_q + POS_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			ovf_q <= 1'b0;
		end else if (accept) begin
			if (last) begin
				pos_q <= '0;
				ovf_q <= 1'b0;
			end else begin
				if (take)
					pos_q <= push_pos;
				if (drop_byte)
					ovf_q <= 1'b1;
			end
		end
	end

endmodule

>>> rtl/core/sfm_queue.sv
// ----------------------------------------------------------------------------
// sfm_queue
// Short first-in first-out queue between the front and the search engine.
// ----------------------------------------------------------------------------
module sfm_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic             not_empty,
	output logic [WIDTH-1:0] pop_data
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_q;
	logic [AW-1:0]    rd_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full      = (count_q == CW'(DEPTH));
	assign not_empty = (count_q != '0);
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign pop_data  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (do_push)
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + AW'(1);
			if (do_pop)
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + AW'(1);
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + CW'(1);
				2'b01:   count_q <= count_q - CW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

>>> rtl/core/sfm_back.sv
// ----------------------------------------------------------------------------
// sfm_back
// Search engine: shifts text bytes into the history window, compares the
// window with the pattern and holds the result in an output register.
// ----------------------------------------------------------------------------
module sfm_back #(
	parameter int MAX_PATTERN = 8,
	parameter int POS_W       = 17
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [sfm_pkg::PAT_W-1:0]     pattern,
	input  logic [sfm_pkg::PLEN_W-1:0]    plen,
	input  logic                          entry_valid,
	input  sfm_pkg::sfm_ctl_t             entry_ctl,
	input  logic [sfm_pkg::BYTE_W-1:0]    entry_byte,
	input  logic [POS_W-1:0]              entry_pos,
	output logic                          entry_pop,
	output logic                          result_valid,
	input  logic                          result_stall,
	output logic                          found,
	output logic [sfm_pkg::START_W-1:0]   match_start,
	output logic                          too_long
);

	localparam int DW = (POS_W > sfm_pkg::START_W) ? POS_W : sfm_pkg::START_W;

	logic [sfm_pkg::BYTE_W-1:0]  hist_q [MAX_PATTERN];
	logic [sfm_pkg::BYTE_W-1:0]  win [MAX_PATTERN];
	logic                        seen_q;
	logic [sfm_pkg::START_W-1:0] first_q;
	logic                        res_valid_q;
	logic                        found_q;
	logic [sfm_pkg::START_W-1:0] start_q;
	logic                        too_long_q;

	logic                        hit;
	logic                        new_match;
	logic                        seen_next;
	logic [sfm_pkg::START_W-1:0] first_next;
	logic [DW-1:0]               diff;
	logic                        out_free;

	assign out_free  = !res_valid_q || !result_stall;
	assign entry_pop = entry_valid && (!entry_ctl.last || out_free);

	always_comb begin
		logic [sfm_pkg::PLEN_W-1:0] pi;
		pi     = '0;
		win[0] = entry_byte;
		for (int k = 1; k < MAX_PATTERN; k++)
			win[k] = hist_q[k-1];
		hit = 1'b1;
		for (int k = 0; k < MAX_PATTERN; k++) begin
			if (sfm_pkg::PLEN_W'(k) < plen) begin
				pi = plen - sfm_pkg::PLEN_W'(k) - sfm_pkg::PLEN_W'(1);
				if (win[k] != pattern[{pi[sfm_pkg::PAT_IDX_W-1:0], 3'b000} +: sfm_pkg::BYTE_W])
					hit = 1'b0;
			end
		end
	end

	assign diff       = DW'(entry_pos) - DW'(plen);
	assign new_match  = entry_ctl.take && !seen_q && (plen != '0)
		&& (entry_pos >= POS_W'(plen)) && hit;
	assign seen_next  = seen_q || new_match;
	assign first_next = new_match ? diff[sfm_pkg::START_W-1:0] : first_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < MAX_PATTERN; k++)
				hist_q[k] <= '0;
			seen_q      <= 1'b0;
			first_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (res_valid_q && !result_stall)
				res_valid_q <= 1'b0;
			if (entry_pop) begin
				if (entry_ctl.last) begin
					for (int k = 0; k < MAX_PATTERN; k++)
						hist_q[k] <= '0;
					seen_q      <= 1'b0;
					first_q     <= '0;
					res_valid_q <= 1'b1;
				end else begin
					if (entry_ctl.take) begin
						for (int k = 0; k < MAX_PATTERN; k++)
							hist_q[k] <= win[k];
					end
					seen_q  <= seen_next;
					first_q <= first_next;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (entry_pop && entry_ctl.last) begin
			found_q    <= (plen == '0) || seen_next;
			start_q    <= first_next;
			too_long_q <= entry_ctl.too_long;
		end
	end

	assign result_valid = res_valid_q;
	assign found        = found_q;
	assign match_start  = start_q;
	assign too_long     = too_long_q;

endmodule

>>> rtl/core/substring_first_match_unit.sv
// ----------------------------------------------------------------------------
// substring_first_match_unit
// First-occurrence search of a configured pattern in a streamed text.
// ----------------------------------------------------------------------------
// One text byte is taken per cycle while text_stall is low. A front stage
// counts position and overflow, a two-entry queue decouples it from the search
// engine, and the engine compares the history window with the pattern
// combinationally. The last transaction of a text is written into a queue slot
// when it is accepted and its result then into the output register, later
// while earlier entries still wait in the queue or an earlier result is not
// yet taken; the result is held until taken.
// Pattern lengths above MAX_PATTERN act as MAX_PATTERN; bytes beyond
// MAX_TEXT are not searched and set too_long.
// ----------------------------------------------------------------------------
module substring_first_match_unit #(
	parameter int MAX_PATTERN = 8,
	parameter int MAX_TEXT    = 65536
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [sfm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [sfm_pkg::PAT_W-1:0]     cfg_data,
	input  logic                          text_valid,
	output logic                          text_stall,
	input  logic [sfm_pkg::BYTE_W-1:0]    text_byte,
	input  logic                          has_byte,
	input  logic                          last,
	output logic                          result_valid,
	input  logic                          result_stall,
	output logic                          found,
	output logic [sfm_pkg::START_W-1:0]   match_start,
	output logic                          too_long
);

	localparam int POS_W   = $clog2(MAX_TEXT + 1);
	localparam int ENTRY_W = sfm_pkg::CTL_W + sfm_pkg::BYTE_W + POS_W;
	localparam int Q_DEPTH = 2;

	logic [sfm_pkg::PAT_W-1:0]  pattern_q;
	logic [sfm_pkg::PLEN_W-1:0] plen_q;
	logic [sfm_pkg::PLEN_W-1:0] plen_eff;

	logic                       push;
	sfm_pkg::sfm_ctl_t          push_ctl;
	logic [sfm_pkg::BYTE_W-1:0] push_byte;
	logic [POS_W-1:0]           push_pos;
	logic                       queue_full;
	logic                       queue_pop;
	logic                       queue_valid;
	logic [ENTRY_W-1:0]         queue_data;
	sfm_pkg::sfm_ctl_t          entry_ctl;
	logic [sfm_pkg::BYTE_W-1:0] entry_byte;
	logic [POS_W-1:0]           entry_pos;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_q <= '0;
			plen_q    <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				sfm_pkg::CFG_PATTERN_BYTES:  pattern_q <= cfg_data;
				sfm_pkg::CFG_PATTERN_LENGTH: plen_q    <= cfg_data[sfm_pkg::PLEN_W-1:0];
				default: ;
			endcase
		end
	end

	assign plen_eff = (plen_q > sfm_pkg::PLEN_W'(MAX_PATTERN))
		? sfm_pkg::PLEN_W'(MAX_PATTERN) : plen_q;

	sfm_front #(
		.MAX_TEXT (MAX_TEXT),
		.POS_W    (POS_W)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.text_valid (text_valid),
		.text_stall (text_stall),
		.text_byte  (text_byte),
		.has_byte   (has_byte),
		.last       (last),
		.queue_full (queue_full),
		.push       (push),
		.push_ctl   (push_ctl),
		.push_byte  (push_byte),
		.push_pos   (push_pos)
	);

	sfm_queue #(
		.WIDTH (ENTRY_W),
		.DEPTH (Q_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data ({push_ctl, push_byte, push_pos}),
		.full      (queue_full),
		.pop       (queue_pop),
		.not_empty (queue_valid),
		.pop_data  (queue_data)
	);

	assign {entry_ctl, entry_byte, entry_pos} = queue_data;

	sfm_back #(
		.MAX_PATTERN (MAX_PATTERN),
		.POS_W       (POS_W)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.pattern      (pattern_q),
		.plen         (plen_eff),
		.entry_valid  (queue_valid),
		.entry_ctl    (entry_ctl),
		.entry_byte   (entry_byte),
		.entry_pos    (entry_pos),
		.entry_pop    (queue_pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.found        (found),
		.match_start  (match_start),
		.too_long     (too_long)
	);

endmodule
